>>> rtl/core/udf_pkg.sv
`timescale 1ns / 1ps

package udf_pkg;

  localparam int unsigned NumBytes  = 7;
  localparam int unsigned CrcStages = 7;
  localparam int unsigned LongFrom  = 3;

  localparam logic [7:0] CrcPoly   = 8'h07;
  localparam logic [7:0] RegMax    = 8'h7F;
  localparam logic [7:0] NodeMax   = 8'd3;
  localparam logic [7:0] WriteFlag = 8'h80;

  localparam logic [7:0] SyncReset  = 8'd5;
  localparam logic [7:0] ReplyReset = 8'd255;

  localparam logic [2:0] LastWrite   = 3'd7;
  localparam logic [2:0] LastRequest = 3'd3;
  localparam logic [2:0] LastSingle  = 3'd0;

  typedef enum logic [1:0] {
    ActWrite   = 2'd0,
    ActRequest = 2'd1,
    ActCheck   = 2'd2,
    ActNone    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatParamErr = 2'd1,
    StatNoDevice = 2'd2,
    StatCrcErr   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CfgSyncByte  = 2'd0,
    CfgReplyNode = 2'd1
  } cfg_index_e;

  typedef struct packed {
    logic [NumBytes-1:0][7:0] bytes;
    logic [7:0]               crc;
    logic [7:0]               rx_crc;
    logic                     long_crc;
    logic                     chk;
    logic                     emit;
    logic [2:0]               last_idx;
    status_e                  status;
  } udf_item_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[7] ^ b[k];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/uart_register_datagram_framer.sv
`timescale 1ns / 1ps

// Channel  | Valid / ready          | Words
// ---------+------------------------+-------------------------------------------------
// input    | in_valid_i / in_ready_o | action, node_addr, reg_index, data_word, reply_frame
// output   | out_valid_o / out_ready_i | out_byte, last, status, reply_data
// config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i (always ready)
//
// An item passes a decode register, seven CRC stages of one byte each and an
// output register. While out_ready_i is high, the output register gives one word per
// cycle: eight for a write, four for a read request and one for a check or an error,
// which sets the sustained rate.
// Reset clears all valid bits and loads the sync byte 5 and reply address 255.
// A stall on the output backs up stage by stage; no word is lost or repeated.

module uart_register_datagram_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  node_addr_i,
  input  logic [7:0]  reg_index_i,
  input  logic [31:0] data_word_i,
  input  logic [63:0] reply_frame_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic [31:0] reply_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import udf_pkg::*;

  logic [7:0] sync_q, reply_node_q;
  udf_item_t  dec_item, crc_item;
  logic       dec_valid, dec_ready, crc_valid, crc_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q       <= SyncReset;
      reply_node_q <= ReplyReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgSyncByte:  sync_q       <= cfg_data_i;
        CfgReplyNode: reply_node_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  udf_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .node_addr_i   (node_addr_i),
    .reg_index_i   (reg_index_i),
    .data_word_i   (data_word_i),
    .reply_frame_i (reply_frame_i),
    .sync_byte_i   (sync_q),
    .reply_node_i  (reply_node_q),
    .dout_valid_o  (dec_valid),
    .dout_ready_i  (dec_ready),
    .dout_o        (dec_item)
  );

  udf_crc_pipe u_crc_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .din_valid_i  (dec_valid),
    .din_ready_o  (dec_ready),
    .din_i        (dec_item),
    .dout_valid_o (crc_valid),
    .dout_ready_i (crc_ready),
    .dout_o       (crc_item)
  );

  udf_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .din_valid_i  (crc_valid),
    .din_ready_o  (crc_ready),
    .din_i        (crc_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o),
    .status_o     (status_o),
    .reply_data_o (reply_data_o)
  );

endmodule

>>> rtl/core/udf_decode.sv
`timescale 1ns / 1ps

module udf_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [7:0]        node_addr_i,
  input  logic [7:0]        reg_index_i,
  input  logic [31:0]       data_word_i,
  input  logic [63:0]       reply_frame_i,
  input  logic [7:0]        sync_byte_i,
  input  logic [7:0]        reply_node_i,
  output logic              dout_valid_o,
  input  logic              dout_ready_i,
  output udf_pkg::udf_item_t dout_o
);
  import udf_pkg::*;

  udf_item_t item_d, item_q;
  logic      valid_q;
  action_e   act;

  assign act        = action_e'(action_i);
  assign in_ready_o = !valid_q || dout_ready_i;

  always_comb begin
    item_d          = '0;
    item_d.status   = StatOk;
    item_d.last_idx = LastSingle;
    if (act == ActCheck) begin
      for (int k = 0; k < NumBytes; k++) begin
        item_d.bytes[k] = reply_frame_i[63-8*k -: 8];
      end
      item_d.rx_crc   = reply_frame_i[7:0];
      item_d.long_crc = 1'b1;
      if (reg_index_i > RegMax) begin
        item_d.status = StatParamErr;
      end else if (reply_frame_i[63:56] != sync_byte_i ||
                   reply_frame_i[55:48] != reply_node_i ||
                   reply_frame_i[47:40] != reg_index_i) begin
        item_d.status = StatNoDevice;
      end else begin
        item_d.chk = 1'b1;
      end
    end else if (act == ActNone || node_addr_i > NodeMax || reg_index_i > RegMax) begin
      item_d.status = StatParamErr;
    end else begin
      item_d.emit     = 1'b1;
      item_d.bytes[0] = sync_byte_i;
      item_d.bytes[1] = node_addr_i;
      if (act == ActWrite) begin
        item_d.bytes[2] = reg_index_i | WriteFlag;
        item_d.bytes[3] = data_word_i[31:24];
        item_d.bytes[4] = data_word_i[23:16];
        item_d.bytes[5] = data_word_i[15:8];
        item_d.bytes[6] = data_word_i[7:0];
        item_d.long_crc = 1'b1;
        item_d.last_idx = LastWrite;
      end else begin
        item_d.bytes[2] = reg_index_i;
        item_d.last_idx = LastRequest;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign dout_valid_o = valid_q;
  assign dout_o       = item_q;

endmodule

>>> rtl/core/udf_crc_pipe.sv
`timescale 1ns / 1ps

module udf_crc_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               din_valid_i,
  output logic               din_ready_o,
  input  udf_pkg::udf_item_t din_i,
  output logic               dout_valid_o,
  input  logic               dout_ready_i,
  output udf_pkg::udf_item_t dout_o
);
  import udf_pkg::*;

  udf_item_t            pipe_item [CrcStages+1];
  logic [CrcStages:0]   pipe_vld;
  logic [CrcStages:0]   rdy;

  assign pipe_item[0]   = din_i;
  assign pipe_vld[0]    = din_valid_i;
  assign rdy[CrcStages] = dout_ready_i;
  assign din_ready_o    = rdy[0];

  for (genvar s = 0; s < CrcStages; s++) begin : g_stage
    udf_item_t item_d;

    assign rdy[s] = !pipe_vld[s+1] || rdy[s+1];

    always_comb begin
      item_d = pipe_item[s];
      if (s < LongFrom || pipe_item[s].long_crc) begin
        item_d.crc = crc_feed(pipe_item[s].crc, pipe_item[s].bytes[s]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_vld[s+1] <= 1'b0;
      end else if (rdy[s]) begin
        pipe_vld[s+1] <= pipe_vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && pipe_vld[s]) begin
        pipe_item[s+1] <= item_d;
      end
    end
  end

  assign dout_valid_o = pipe_vld[CrcStages];
  assign dout_o       = pipe_item[CrcStages];

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_vld[1] && !rdy[1] |=> pipe_vld[1] && $stable(pipe_item[1]))
    else $error("stalled first CRC stage lost its word");

  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dout_valid_o && !dout_ready_i |=> dout_valid_o && $stable(dout_o))
    else $error("stalled CRC pipe output changed");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_vld[1] |-> rdy[0])
    else $error("empty first stage refused a word");

endmodule

>>> rtl/core/udf_serializer.sv
`timescale 1ns / 1ps

module udf_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               din_valid_i,
  output logic               din_ready_o,
  input  udf_pkg::udf_item_t din_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               last_o,
  output logic [1:0]         status_o,
  output logic [31:0]        reply_data_o
);
  import udf_pkg::*;

  udf_item_t   cur_q;
  logic        valid_q;
  logic [2:0]  cnt_q, cnt_d;
  status_e     status_q, status_d;
  logic [31:0] reply_q, reply_d;
  logic        is_last;
  logic        load;

  assign is_last     = (cnt_q == cur_q.last_idx);
  assign din_ready_o = !valid_q || (out_ready_i && is_last);
  assign load        = din_valid_i && din_ready_o;

  always_comb begin
    status_d = din_i.status;
    reply_d  = '0;
    if (din_i.chk) begin
      if (din_i.crc != din_i.rx_crc) begin
        status_d = StatCrcErr;
      end else begin
        reply_d = {din_i.bytes[3], din_i.bytes[4], din_i.bytes[5], din_i.bytes[6]};
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = '0;
    end else if (valid_q && out_ready_i) begin
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (valid_q && out_ready_i && is_last) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q    <= din_i;
      status_q <= status_d;
      reply_q  <= reply_d;
    end
  end

  always_comb begin
    out_byte_o = '0;
    if (cur_q.emit) begin
      out_byte_o = is_last ? cur_q.crc : cur_q.bytes[cnt_q];
    end
  end

  assign out_valid_o  = valid_q;
  assign last_o       = is_last;
  assign status_o     = status_q;
  assign reply_data_o = reply_q;

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatOk |-> last_o && out_byte_o == 8'd0)
    else $error("error result is not a single zero word");

  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && cnt_q == $past(cnt_q) + 3'd1)
    else $error("frame lost a byte");

  a_build_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_byte_o != 8'd0 |-> reply_data_o == 32'd0)
    else $error("build word carries reply data");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import udf_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned HoldoffCycles = 400;
  localparam logic [1:0]  CfgSpareLow   = 2'd2;
  localparam logic [1:0]  CfgSpareHigh  = 2'd3;

  typedef struct packed {
    action_e     action;
    logic [7:0]  node_addr;
    logic [7:0]  reg_index;
    logic [31:0] data_word;
    logic [63:0] reply_frame;
  } request_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    status_e     status;
    logic [31:0] reply_data;
  } word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i      = '0;
  logic [7:0]  node_addr_i   = '0;
  logic [7:0]  reg_index_i   = '0;
  logic [31:0] data_word_i   = '0;
  logic [63:0] reply_frame_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic [1:0]  status_o;
  logic [31:0] reply_data_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [7:0]  cfg_data_i    = '0;

  logic [7:0]  sync_value       = SyncReset;
  logic [7:0]  reply_addr_value = ReplyReset;
  word_t       outgoing_words[$];

  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;
  int unsigned send_idle_pct   = 28;
  int unsigned recv_idle_pct   = 87;
  int unsigned holdoff_request = 0;
  int unsigned holdoff_left    = 0;

  uart_register_datagram_framer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .node_addr_i   (node_addr_i),
    .reg_index_i   (reg_index_i),
    .data_word_i   (data_word_i),
    .reply_frame_i (reply_frame_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .reply_data_o  (reply_data_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] crc8_lsb_first(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      r = {r[6:0], 1'b0} ^ (((r[7] ^ b[i]) == 1'b1) ? CrcPoly : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [63:0] reply_frame_for(input logic [7:0] index,
                                                  input logic [31:0] data);
    logic [63:0] frame;
    logic [7:0]  crc;
    frame = {sync_value, reply_addr_value, index, data, 8'h00};
    crc = 8'h00;
    for (int k = 0; k < 7; k++) begin
      crc = crc8_lsb_first(crc, frame[63 - 8 * k -: 8]);
    end
    frame[7:0] = crc;
    return frame;
  endfunction

  function automatic request_t make_request(input action_e action, input logic [7:0] node,
                                            input logic [7:0] index, input logic [31:0] data,
                                            input logic [63:0] frame);
    request_t req;
    req.action      = action;
    req.node_addr   = node;
    req.reg_index   = index;
    req.data_word   = data;
    req.reply_frame = frame;
    return req;
  endfunction

  // Most requests are well formed so that checks get past the header and CRC tests.
  function automatic request_t random_request();
    request_t    req;
    logic [7:0]  flip;
    int unsigned pick;
    pick = $urandom_range(99);
    flip = 8'($urandom_range(255, 1));
    req  = make_request(ActWrite, 8'($urandom_range(NodeMax)), 8'($urandom_range(RegMax)),
                        $urandom, {$urandom, $urandom});
    if (pick < 20) begin
      req.action = ActRequest;
    end else if (pick < 50) begin
      req.action      = ActCheck;
      req.reply_frame = reply_frame_for(req.reg_index, req.data_word);
      case ($urandom_range(9))
        0: req.reply_frame[63:56] = req.reply_frame[63:56] ^ flip;
        1: req.reply_frame[55:48] = req.reply_frame[55:48] ^ flip;
        2: req.reply_frame[47:40] = req.reply_frame[47:40] ^ flip;
        3: req.reply_frame[7:0]   = req.reply_frame[7:0] ^ flip;
        4: req.reply_frame[39:32] = req.reply_frame[39:32] ^ flip;
        5: req.reg_index          = req.reg_index | WriteFlag;
        default: ;
      endcase
    end else if (pick < 65) begin
      req.action    = action_e'(2'($urandom_range(3)));
      req.node_addr = 8'($urandom_range(255));
      req.reg_index = 8'($urandom_range(255));
    end
    return req;
  endfunction

  task automatic push_word(input logic [7:0] b, input logic last, input status_e status,
                           input logic [31:0] data);
    word_t w;
    w.out_byte   = b;
    w.last       = last;
    w.status     = status;
    w.reply_data = data;
    outgoing_words.push_back(w);
  endtask

  task automatic frame_datagram(input request_t req);
    logic [7:0]  bytes [8];
    logic [7:0]  crc;
    int unsigned count;
    crc = 8'h00;
    if (req.action == ActCheck) begin
      if (req.reg_index > RegMax) begin
        push_word(8'h00, 1'b1, StatParamErr, 32'h0);
      end else if (req.reply_frame[63:56] != sync_value ||
                   req.reply_frame[55:48] != reply_addr_value ||
                   req.reply_frame[47:40] != req.reg_index) begin
        push_word(8'h00, 1'b1, StatNoDevice, 32'h0);
      end else begin
        for (int k = 0; k < 7; k++) begin
          crc = crc8_lsb_first(crc, req.reply_frame[63 - 8 * k -: 8]);
        end
        if (crc != req.reply_frame[7:0]) begin
          push_word(8'h00, 1'b1, StatCrcErr, 32'h0);
        end else begin
          push_word(8'h00, 1'b1, StatOk, req.reply_frame[39:8]);
        end
      end
    end else if (req.action == ActNone || req.node_addr > NodeMax || req.reg_index > RegMax) begin
      push_word(8'h00, 1'b1, StatParamErr, 32'h0);
    end else begin
      bytes[0] = sync_value;
      bytes[1] = req.node_addr;
      if (req.action == ActWrite) begin
        bytes[2] = req.reg_index | WriteFlag;
        bytes[3] = req.data_word[31:24];
        bytes[4] = req.data_word[23:16];
        bytes[5] = req.data_word[15:8];
        bytes[6] = req.data_word[7:0];
        count    = 8;
      end else begin
        bytes[2] = req.reg_index;
        count    = 4;
      end
      for (int k = 0; k < count - 1; k++) begin
        crc = crc8_lsb_first(crc, bytes[k]);
      end
      bytes[count - 1] = crc;
      for (int k = 0; k < count; k++) begin
        push_word(bytes[k], (k == count - 1), StatOk, 32'h0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      frame_datagram(make_request(action_e'(action_i), node_addr_i, reg_index_i, data_word_i,
                                  reply_frame_i));
    end
  end

  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outgoing_words.size() == 0) begin
        $error("unexpected word: out_byte %0h last %0d status %0d reply_data %0h",
               out_byte_o, last_o, status_o, reply_data_o);
        error_count++;
      end else begin
        want = outgoing_words.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (reply_data_o !== want.reply_data) begin
          $error("reply_data: expected %0h, got %0h", want.reply_data, reply_data_o);
          error_count++;
        end
      end
    end
  end

  // The receiver takes a hold-off request at a negative edge and counts it down itself.
  always @(negedge clk_i) begin
    if (holdoff_request != 0) begin
      holdoff_left    = holdoff_request;
      holdoff_request = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("uart_register_datagram_framer verification failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken,
  // with valid still high so that a following word can go out back to back.
  task automatic send_word(input request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= req.action;
    node_addr_i   <= req.node_addr;
    reg_index_i   <= req.reg_index;
    data_word_i   <= req.data_word;
    reply_frame_i <= req.reply_frame;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (outgoing_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [7:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (index == CfgSyncByte) begin
      sync_value = value;
    end else if (index == CfgReplyNode) begin
      reply_addr_value = value;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    @(posedge clk_i);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    @(negedge clk_i);
  endtask

  task automatic send_random_burst(input int unsigned count);
    repeat (count) send_word(random_request());
    release_input();
  endtask

  task automatic test_directed_frames();
    send_word(make_request(ActWrite, 8'd0, 8'd0, 32'h0, 64'h0));
    send_word(make_request(ActWrite, NodeMax, RegMax, 32'hFFFF_FFFF, 64'h0));
    send_word(make_request(ActRequest, 8'd0, 8'd0, 32'h0, 64'h0));
    send_word(make_request(ActRequest, NodeMax, RegMax, 32'h0, 64'h0));
    send_word(make_request(ActWrite, 8'd4, 8'd0, 32'h1, 64'h0));
    send_word(make_request(ActWrite, 8'd255, 8'd5, 32'h2, 64'h0));
    send_word(make_request(ActWrite, 8'd1, 8'd128, 32'h3, 64'h0));
    send_word(make_request(ActRequest, 8'd2, 8'd255, 32'h0, 64'h0));
    send_word(make_request(ActRequest, 8'd4, 8'd10, 32'h0, 64'h0));
    send_word(make_request(ActNone, 8'd0, 8'd0, 32'h0, 64'h0));
    send_word(make_request(ActNone, 8'd255, 8'd255, 32'hFFFF_FFFF, '1));
    send_word(make_request(ActCheck, 8'd0, 8'd0, 32'h0, reply_frame_for(8'd0, 32'h0)));
    send_word(make_request(ActCheck, 8'd255, RegMax, 32'h0,
                           reply_frame_for(RegMax, 32'hFFFF_FFFF)));
    send_word(make_request(ActCheck, 8'd0, 8'd128, 32'h0, reply_frame_for(8'd128, 32'h55)));
    send_word(make_request(ActCheck, 8'd0, 8'd255, 32'h0, '1));
    send_word(make_request(ActCheck, 8'd0, 8'd9, 32'h0,
                           reply_frame_for(8'd9, 32'h1234_5678) ^ 64'h0100_0000_0000_0000));
    send_word(make_request(ActCheck, 8'd0, 8'd9, 32'h0,
                           reply_frame_for(8'd9, 32'h1234_5678) ^ 64'h0080_0000_0000_0000));
    send_word(make_request(ActCheck, 8'd0, 8'd9, 32'h0,
                           reply_frame_for(8'd9, 32'h1234_5678) ^ 64'h0000_4000_0000_0000));
    send_word(make_request(ActCheck, 8'd0, 8'd9, 32'h0,
                           reply_frame_for(8'd9, 32'h1234_5678) ^ 64'h0000_0000_0000_0001));
    send_word(make_request(ActCheck, 8'd0, 8'd0, 32'h0, 64'h0));
    send_word(make_request(ActCheck, 8'd0, RegMax, 32'h0, '1));
    send_word(make_request(ActWrite, 8'd2, 8'h55, 32'hA5A5_A5A5, 64'h0));
    send_word(make_request(ActRequest, 8'd1, 8'h2A, 32'hFFFF_FFFF, '1));
    release_input();
  endtask

  task automatic test_register_settings();
    write_register(CfgSyncByte, 8'h00);
    write_register(CfgReplyNode, 8'h00);
    send_random_burst(8);
    write_register(CfgSyncByte, 8'hFF);
    write_register(CfgReplyNode, 8'hFF);
    send_random_burst(8);
    write_register(CfgSyncByte, 8'($urandom_range(255)));
    write_register(CfgReplyNode, 8'($urandom_range(255)));
    send_random_burst(8);
    write_register(CfgSpareLow, 8'($urandom_range(255)));
    write_register(CfgSpareHigh, 8'($urandom_range(255)));
    send_random_burst(8);
    write_register(CfgSyncByte, SyncReset);
    write_register(CfgReplyNode, ReplyReset);
    send_random_burst(8);
  endtask

  task automatic test_output_holdoff();
    set_idling(0, 0);
    @(posedge clk_i);
    holdoff_request = HoldoffCycles;
    @(negedge clk_i);
    repeat (40) begin
      send_word(make_request(ActWrite, 8'($urandom_range(NodeMax)),
                             8'($urandom_range(RegMax)), $urandom, 64'h0));
    end
    release_input();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      write_register(CfgSyncByte, 8'($urandom_range(255)));
      write_register(CfgReplyNode, 8'($urandom_range(255)));
      case (phase)
        0:       set_idling(28, 87);
        1:       set_idling(87, 28);
        default: set_idling(0, 0);
      endcase
      send_random_burst(60);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_frames();
    test_register_settings();
    test_output_holdoff();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("uart_register_datagram_framer verification clean");
    end else begin
      $display("uart_register_datagram_framer verification failed");
    end
    $finish;
  end

endmodule
